/* rtl/tgs_pkg.sv */
// ----------------------------------------------------------------------------
// Target gate and store package
// Shared types and constants for the target table, the gate distance unit
// and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package tgs_pkg;

  localparam int MAX_TARGETS_DEF = 32;
  localparam int COORD_W         = 16;
  localparam int POINTS_W        = 12;
  localparam int SLOT_W          = 6;
  localparam int TOTAL_W         = 7;
  localparam int SQ_W            = 32;

  localparam logic [15:0] GATE_RESET = 16'd512;

  typedef enum logic [2:0] {
    ACT_UPDATED = 3'd0,
    ACT_KEPT    = 3'd1,
    ACT_INSERTED = 3'd2,
    ACT_DROPPED = 3'd3,
    ACT_DUMP    = 3'd4
  } action_t;

  typedef enum logic {
    CMD_ASSOC = 1'b0,
    CMD_DUMP  = 1'b1
  } cmd_t;

  typedef struct packed {
    logic [POINTS_W-1:0]       pts;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] x;
  } entry_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } dist_st_t;

endpackage

`default_nettype wire

/* rtl/tgs_ram.sv */
// ----------------------------------------------------------------------------
// Generic synchronous RAM
// One write port and one read port with an enable; the read data is
// registered and holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module tgs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/tgs_dist.sv */
// ----------------------------------------------------------------------------
// Gate distance unit
// Squares the x and y offsets between the centroid and a stored entry in a
// registered stage, then sums them and compares against the squared gate.
// ----------------------------------------------------------------------------
`default_nettype none

module tgs_dist (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       valid_in,
  input  wire logic signed [15:0]         cx,
  input  wire logic signed [15:0]         cy,
  input  wire tgs_pkg::entry_t            entry_in,
  input  wire logic [31:0]                gate2,
  output tgs_pkg::dist_st_t               st,
  output tgs_pkg::entry_t                 entry_q
);

  import tgs_pkg::*;

  logic signed [COORD_W:0]     dx;
  logic signed [COORD_W:0]     dy;
  logic signed [2*COORD_W+1:0] px;
  logic signed [2*COORD_W+1:0] py;
  logic [SQ_W-1:0]             sqx_r;
  logic [SQ_W-1:0]             sqy_r;
  logic                        valid_r;
  logic [SQ_W:0]               d2;

  assign dx = {cx[COORD_W-1], cx} - {entry_in.x[COORD_W-1], entry_in.x};
  assign dy = {cy[COORD_W-1], cy} - {entry_in.y[COORD_W-1], entry_in.y};
  assign px = dx * dx;
  assign py = dy * dy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_in;
    end
    sqx_r   <= px[SQ_W-1:0];
    sqy_r   <= py[SQ_W-1:0];
    entry_q <= entry_in;
  end

  assign d2       = {1'b0, sqx_r} + {1'b0, sqy_r};
  assign st.valid = valid_r;
  assign st.hit   = valid_r && (d2 < {1'b0, gate2});

endmodule

`default_nettype wire

/* rtl/target_gate_and_store_unit.sv */
// ----------------------------------------------------------------------------
// Target gate and store unit
// Associates cluster centroids with a table of stored targets held in RAM,
// and lists the table on request.
// ----------------------------------------------------------------------------
// The table lives in one single-port-read RAM, one entry per read. An
// associate item scans the stored entries in slot order at one entry per
// cycle through the RAM read, a squaring stage and a compare, and stops at
// the first entry inside the gate. With no match, the result is loaded
// once every stored entry has passed the compare, or as soon as the scan
// finds nothing to read for an empty table. It always gives one result.
// A dump item gives one result per stored entry, passing through a read
// state and an output state for each entry, since each needs its own RAM
// read, and none for an empty table. A result waits in the output register
// while the output is stalled, and so does the item behind it. One item is
// handled at a time; the next is accepted in the cycle after the last
// result of the previous one is loaded into the output register. The table
// needs no clearing after reset, since only slots below the stored count
// are read.
// ----------------------------------------------------------------------------
`default_nettype none

module target_gate_and_store_unit #(
  parameter int MAX_TARGETS = tgs_pkg::MAX_TARGETS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // in_tdata: centroid_x[15:0], centroid_y[31:16], cluster_points[43:32]
  input  wire logic [47:0] in_tdata,
  // in_tuser: cmd[0]
  input  wire logic [0:0]  in_tuser,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // out_tdata: slot[5:0], entry_x[21:6], entry_y[37:22],
  // entry_points[49:38], stored_total[56:50]
  output logic [63:0]      out_tdata,
  // out_tuser: action[2:0]
  output logic [2:0]       out_tuser,
  output logic             out_tlast,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  input  wire logic [15:0] cfg_data,
  input  wire logic        cfg_valid,
  output logic             cfg_ready
);

  import tgs_pkg::*;

  localparam int AW = (MAX_TARGETS > 1) ? $clog2(MAX_TARGETS) : 1;
  localparam int CW = $clog2(MAX_TARGETS + 1);
  localparam logic [CW-1:0] FULL_COUNT = CW'(MAX_TARGETS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DECIDE,
    S_DUMP_RD,
    S_DUMP_OUT
  } state_t;

  state_t            state_r;
  logic [31:0]       gate2_r;
  logic [CW-1:0]     total_r;
  logic [CW-1:0]     rd_idx_r;
  logic              rd_v_r;
  logic [AW-1:0]     idx1_r;
  logic [AW-1:0]     idx2_r;
  logic signed [15:0] cx_r;
  logic signed [15:0] cy_r;
  logic [11:0]       cp_r;
  logic              m_hit_r;
  logic [AW-1:0]     m_idx_r;
  entry_t            m_entry_r;

  logic              out_valid_r;
  logic [63:0]       out_data_r;
  logic [2:0]        out_user_r;
  logic              out_last_r;

  logic              out_free;
  logic              out_load;
  logic              scan_issue;
  logic              ram_re;
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  entry_t            ram_rdata;
  entry_t            new_entry;
  dist_st_t          dist_st;
  entry_t            dist_entry;

  action_t           dec_action;
  logic [AW-1:0]     dec_slot;
  entry_t            dec_entry;
  logic              dec_we;
  logic [CW-1:0]     dec_total;
  logic              dump_last;

  assign cfg_ready  = 1'b1;
  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;
  assign out_load   = ((state_r == S_DECIDE) || (state_r == S_DUMP_OUT)) && out_free;

  assign new_entry.x   = cx_r;
  assign new_entry.y   = cy_r;
  assign new_entry.pts = cp_r;

  assign scan_issue = (state_r == S_SCAN) && (rd_idx_r < total_r);
  assign ram_re     = scan_issue || (state_r == S_DUMP_RD);
  assign ram_we     = (state_r == S_DECIDE) && out_free && dec_we;
  assign dump_last  = ({1'b0, rd_idx_r} + {{CW{1'b0}}, 1'b1}) == {1'b0, total_r};

  always_comb begin
    dec_action = ACT_DROPPED;
    dec_slot   = '0;
    dec_entry  = '0;
    dec_we     = 1'b0;
    dec_total  = total_r;
    ram_waddr  = m_idx_r;
    if (m_hit_r) begin
      dec_slot = m_idx_r;
      if (m_entry_r.pts < cp_r) begin
        dec_action = ACT_UPDATED;
        dec_entry  = new_entry;
        dec_we     = 1'b1;
      end else begin
        dec_action = ACT_KEPT;
        dec_entry  = m_entry_r;
      end
    end else if (total_r != FULL_COUNT) begin
      dec_action = ACT_INSERTED;
      dec_slot   = total_r[AW-1:0];
      dec_entry  = new_entry;
      dec_we     = 1'b1;
      dec_total  = total_r + {{(CW-1){1'b0}}, 1'b1};
      ram_waddr  = total_r[AW-1:0];
    end
  end

  tgs_ram #(
    .WIDTH($bits(entry_t)),
    .DEPTH(MAX_TARGETS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (new_entry),
    .re    (ram_re),
    .raddr (rd_idx_r[AW-1:0]),
    .rdata (ram_rdata)
  );

  tgs_dist u_dist (
    .clk      (clk),
    .rst_n    (rst_n),
    .valid_in (rd_v_r),
    .cx       (cx_r),
    .cy       (cy_r),
    .entry_in (ram_rdata),
    .gate2    (gate2_r),
    .st       (dist_st),
    .entry_q  (dist_entry)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      gate2_r     <= 32'(GATE_RESET) * 32'(GATE_RESET);
      total_r     <= '0;
      rd_idx_r    <= '0;
      rd_v_r      <= 1'b0;
      m_hit_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        gate2_r <= 32'(cfg_data) * 32'(cfg_data);
      end
      if (out_valid_r && out_tready && !out_load) begin
        out_valid_r <= 1'b0;
      end
      rd_v_r <= scan_issue;
      idx1_r <= rd_idx_r[AW-1:0];
      idx2_r <= idx1_r;

      unique case (state_r)
        S_IDLE: begin
          if (in_tvalid) begin
            cx_r     <= in_tdata[15:0];
            cy_r     <= in_tdata[31:16];
            cp_r     <= in_tdata[43:32];
            rd_idx_r <= '0;
            if (in_tuser[0] == CMD_DUMP) begin
              if (total_r != '0) begin
                state_r <= S_DUMP_RD;
              end
            end else begin
              state_r <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          if (scan_issue) begin
            rd_idx_r <= rd_idx_r + {{(CW-1){1'b0}}, 1'b1};
          end
          if (dist_st.hit) begin
            m_hit_r   <= 1'b1;
            m_idx_r   <= idx2_r;
            m_entry_r <= dist_entry;
            state_r   <= S_DECIDE;
          end else if (!scan_issue && !rd_v_r && !dist_st.valid) begin
            m_hit_r <= 1'b0;
            state_r <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (out_free) begin
            total_r     <= dec_total;
            out_valid_r <= 1'b1;
            out_user_r  <= dec_action;
            out_last_r  <= 1'b1;
            out_data_r  <= {7'd0, TOTAL_W'(dec_total), dec_entry.pts, dec_entry.y,
                            dec_entry.x, SLOT_W'(dec_slot)};
            state_r     <= S_IDLE;
          end
        end
        S_DUMP_RD: begin
          state_r <= S_DUMP_OUT;
        end
        S_DUMP_OUT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            out_user_r  <= ACT_DUMP;
            out_last_r  <= dump_last;
            out_data_r  <= {7'd0, TOTAL_W'(total_r), ram_rdata.pts, ram_rdata.y,
                            ram_rdata.x, SLOT_W'(rd_idx_r[AW-1:0])};
            if (dump_last) begin
              state_r <= S_IDLE;
            end else begin
              rd_idx_r <= rd_idx_r + {{(CW-1){1'b0}}, 1'b1};
              state_r  <= S_DUMP_RD;
            end
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire
